// ----- sv/mpsd_pkg.sv -----
// shared types and codes for the nearest triangle plane block
package mpsd_pkg;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_DEGEN = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] first_z;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] second_z;
        logic signed [31:0] third_x;
        logic signed [31:0] third_y;
        logic signed [31:0] third_z;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] signed_distance;
        logic [9:0]         nearest_face;
        logic               is_inside;
        logic [1:0]         status;
    } t_res;

    typedef struct packed {
        logic               degen;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic signed [31:0] off;
    } t_face;

    typedef struct packed {
        logic  done;
        t_face face;
    } t_ld_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_QUERY
    } t_state;

    typedef enum logic [3:0] {
        L_IDLE,
        L_CROSS,
        L_ABS,
        L_NORM,
        L_LEN,
        L_SQRT,
        L_DIVI,
        L_DIV,
        L_OFF,
        L_FIN
    } t_lstate;

endpackage

// ----- sv/min_plane_signed_distance.sv -----
// top level: face table in one memory, triangle setup and nearest plane query
//
// One command channel: an item transfers at a clock edge with start high and busy
// low. Opcode clear, no-op, a query of an empty table and a load into a full table
// answer in the cycle after the transfer. A load runs through the setup unit: cross
// product, magnitudes, normalizing shifts, squared length, square root, division
// and the offset; a degenerate triangle goes from the normalizing step straight to
// the result. The load's pace is set by the one shared multiplier and the bit-serial
// root and divider. A query streams the face memory one entry per cycle through a
// five-stage distance pipeline and answers once the last entry has left it.
// Each command gives exactly one result, shown for one cycle with o_done high;
// the receiver cannot stall it. busy is low in the cycle the result shows.
// Reset empties the table (face count zero); the memory contents are not
// cleared and there is no clearing pass.
module min_plane_signed_distance
    import mpsd_pkg::*;
#(
    parameter int MAX_FACES = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_cmd i_cmd,
    output logic busy,
    output logic o_done,
    output t_res o_res
);

    localparam int IW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int CW = $clog2(MAX_FACES + 1);

    t_state r_state, n_state;
    t_face  r_mem [MAX_FACES];
    t_face  r_rd;
    t_ld_out w_ld;

    logic [CW-1:0]      r_count, r_qcnt;
    logic signed [31:0] r_px, r_py, r_pz;
    logic               r_v1, r_v2, r_v3, r_v4;
    logic [IW-1:0]      r_i1, r_i2, r_i3, r_i4;
    logic signed [63:0] r_p [3];
    logic signed [31:0] r_off2, r_off3;
    logic               r_dg2, r_dg3, r_dg4;
    logic signed [65:0] r_s;
    logic signed [37:0] r_val;
    logic               r_found;
    logic [37:0]        r_best;
    logic signed [37:0] r_bestv;
    logic [IW-1:0]      r_besti;
    logic               r_done;
    t_res               r_res;

    logic w_accept, w_full, w_issue, w_qend, w_ld_go;
    logic signed [51:0] w_q30;
    logic signed [37:0] w_v;
    logic [37:0]        w_abs;
    logic signed [31:0] w_sat;

    assign w_accept = start && !busy;
    assign w_full   = (r_count == CW'(MAX_FACES));
    assign w_ld_go  = w_accept && i_cmd.opcode == OP_LOAD && !w_full;
    assign w_issue  = (r_state == S_QUERY) && (r_qcnt != r_count);
    assign w_qend   = (r_state == S_QUERY) && (r_qcnt == r_count)
                      && !r_v1 && !r_v2 && !r_v3 && !r_v4;
    assign w_q30    = 52'(r_s >>> 16) + {{5{r_off3[31]}}, r_off3, 15'b0};
    assign w_v      = 38'((w_q30 + 52'sd8192) >>> 14);
    assign w_abs    = r_val[37] ? 38'(-r_val) : 38'(r_val);
    assign w_sat    = (r_bestv > 38'sd2147483647) ? 32'sh7fffffff :
                      (r_bestv < -38'sd2147483648) ? 32'sh80000000 : 32'(r_bestv);

    mpsd_load u_load (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ld_go),
        .i_cmd   (i_cmd),
        .o_ld    (w_ld)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_ld_go) n_state = S_LOAD;
                else if (w_accept && i_cmd.opcode == OP_QUERY && r_count != '0)
                    n_state = S_QUERY;
            end
            S_LOAD:  if (w_ld.done) n_state = S_IDLE;
            S_QUERY: if (w_qend) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= w_issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            if (w_accept && i_cmd.opcode == OP_CLEAR) r_count <= '0;
            else if (r_state == S_LOAD && w_ld.done) r_count <= r_count + 1'b1;
            r_done <= (w_accept && n_state == S_IDLE) || (r_state == S_LOAD && w_ld.done)
                      || w_qend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD && w_ld.done) r_mem[r_count[IW-1:0]] <= w_ld.face;
        r_rd <= r_mem[r_qcnt[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_px    <= i_cmd.first_x;
            r_py    <= i_cmd.first_y;
            r_pz    <= i_cmd.first_z;
            r_qcnt  <= '0;
            r_found <= 1'b0;
            r_res   <= '{signed_distance: '0, nearest_face: '0, is_inside: 1'b0,
                         status: (i_cmd.opcode == OP_LOAD && w_full) ? ST_FULL :
                                 (i_cmd.opcode == OP_QUERY && r_count == '0) ? ST_EMPTY :
                                 ST_OK};
        end
        if (w_issue) r_qcnt <= r_qcnt + 1'b1;
        r_i1   <= r_qcnt[IW-1:0];
        r_p[0] <= r_rd.nx * r_px;
        r_p[1] <= r_rd.ny * r_py;
        r_p[2] <= r_rd.nz * r_pz;
        r_off2 <= r_rd.off;
        r_dg2  <= r_rd.degen;
        r_i2   <= r_i1;
        r_s    <= 66'(r_p[0]) + 66'(r_p[1]) + 66'(r_p[2]);
        r_off3 <= r_off2;
        r_dg3  <= r_dg2;
        r_i3   <= r_i2;
        r_val  <= w_v;
        r_dg4  <= r_dg3;
        r_i4   <= r_i3;
        if (r_v4 && !r_dg4 && (!r_found || w_abs < r_best)) begin
            r_found <= 1'b1;
            r_best  <= w_abs;
            r_bestv <= r_val;
            r_besti <= r_i4;
        end
        if (r_state == S_LOAD && w_ld.done) begin
            r_res.nearest_face <= 10'(r_count[IW-1:0]);
            r_res.status       <= w_ld.face.degen ? ST_DEGEN : ST_OK;
        end
        if (w_qend) begin
            if (r_found) begin
                r_res.signed_distance <= w_sat;
                r_res.nearest_face    <= 10'(r_besti);
                r_res.is_inside       <= r_bestv[37];
                r_res.status          <= ST_OK;
            end else begin
                r_res.status <= ST_EMPTY;
            end
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ----- sv/mpsd_load.sv -----
// triangle setup unit: cross product, normalize, unit normal and plane offset
module mpsd_load
    import mpsd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_cmd    i_cmd,
    output t_ld_out o_ld
);

    t_lstate r_state, n_state;
    logic [5:0]         r_k;
    logic [1:0]         r_ch;
    logic signed [31:0] r_v0 [3];
    logic signed [32:0] r_e1 [3];
    logic signed [32:0] r_e2 [3];
    logic signed [66:0] r_c [3];
    logic [65:0]        r_m [3];
    logic               r_neg [3];
    logic signed [31:0] r_n [3];
    logic signed [65:0] r_prod;
    logic [63:0]        r_len2;
    logic [63:0]        r_x;
    logic [35:0]        r_rem;
    logic [31:0]        r_root;
    logic [32:0]        r_drem;
    logic [30:0]        r_dvd;
    logic [30:0]        r_q;
    logic signed [66:0] r_acc;
    logic               r_done;
    t_face              r_face;

    logic signed [32:0] w_a, w_b;
    logic signed [65:0] w_prod;
    logic [65:0]        w_or;
    logic [35:0]        w_rem2, w_t;
    logic [32:0]        w_drem2;
    logic [61:0]        w_dvd;
    logic signed [67:0] w_full;
    logic signed [36:0] w_sh;

    always_comb begin
        w_a = '0;
        w_b = '0;
        if (r_state == L_CROSS) begin
            case (r_k)
                6'd0: begin w_a = r_e1[1]; w_b = r_e2[2]; end
                6'd1: begin w_a = r_e1[2]; w_b = r_e2[1]; end
                6'd2: begin w_a = r_e1[2]; w_b = r_e2[0]; end
                6'd3: begin w_a = r_e1[0]; w_b = r_e2[2]; end
                6'd4: begin w_a = r_e1[0]; w_b = r_e2[1]; end
                6'd5: begin w_a = r_e1[1]; w_b = r_e2[0]; end
                default: ;
            endcase
        end else if (r_state == L_LEN) begin
            case (r_k)
                6'd0: begin w_a = {2'b0, r_m[0][30:0]}; w_b = {2'b0, r_m[0][30:0]}; end
                6'd1: begin w_a = {2'b0, r_m[1][30:0]}; w_b = {2'b0, r_m[1][30:0]}; end
                6'd2: begin w_a = {2'b0, r_m[2][30:0]}; w_b = {2'b0, r_m[2][30:0]}; end
                default: ;
            endcase
        end else if (r_state == L_OFF) begin
            case (r_k)
                6'd0: begin w_a = 33'(r_n[0]); w_b = 33'(r_v0[0]); end
                6'd1: begin w_a = 33'(r_n[1]); w_b = 33'(r_v0[1]); end
                6'd2: begin w_a = 33'(r_n[2]); w_b = 33'(r_v0[2]); end
                default: ;
            endcase
        end
    end

    assign w_prod  = w_a * w_b;
    assign w_or    = r_m[0] | r_m[1] | r_m[2];
    assign w_rem2  = {r_rem[33:0], r_x[63:62]};
    assign w_t     = {2'b0, r_root, 2'b01};
    assign w_drem2 = {r_drem[31:0], r_dvd[30]};
    assign w_dvd   = {1'b0, r_m[r_ch][30:0], 30'b0} + 62'(r_root >> 1);
    assign w_full  = 68'sd1073741824 - 68'(r_acc);
    assign w_sh    = 37'(w_full >>> 31);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            L_IDLE:  if (i_start) n_state = L_CROSS;
            L_CROSS: if (r_k == 6'd6) n_state = L_ABS;
            L_ABS:   n_state = L_NORM;
            L_NORM: begin
                if (w_or == '0) n_state = L_FIN;
                else if (w_or[65:31] == '0 && w_or[30]) n_state = L_LEN;
            end
            L_LEN:   if (r_k == 6'd3) n_state = L_SQRT;
            L_SQRT:  if (r_k == 6'd31) n_state = L_DIVI;
            L_DIVI:  n_state = L_DIV;
            L_DIV:   if (r_k == 6'd30) n_state = (r_ch == 2'd2) ? L_OFF : L_DIVI;
            L_OFF:   if (r_k == 6'd3) n_state = L_FIN;
            L_FIN:   n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == L_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        r_k    <= (n_state != r_state) ? 6'd0 : r_k + 6'd1;
        case (r_state)
            L_IDLE: begin
                r_v0[0] <= i_cmd.first_x;
                r_v0[1] <= i_cmd.first_y;
                r_v0[2] <= i_cmd.first_z;
                r_e1[0] <= 33'(i_cmd.second_x) - 33'(i_cmd.first_x);
                r_e1[1] <= 33'(i_cmd.second_y) - 33'(i_cmd.first_y);
                r_e1[2] <= 33'(i_cmd.second_z) - 33'(i_cmd.first_z);
                r_e2[0] <= 33'(i_cmd.third_x) - 33'(i_cmd.first_x);
                r_e2[1] <= 33'(i_cmd.third_y) - 33'(i_cmd.first_y);
                r_e2[2] <= 33'(i_cmd.third_z) - 33'(i_cmd.first_z);
                r_len2  <= '0;
                r_acc   <= '0;
                r_ch    <= 2'd0;
            end
            L_CROSS: begin
                case (r_k)
                    6'd1: r_c[0] <= 67'(r_prod);
                    6'd2: r_c[0] <= r_c[0] - 67'(r_prod);
                    6'd3: r_c[1] <= 67'(r_prod);
                    6'd4: r_c[1] <= r_c[1] - 67'(r_prod);
                    6'd5: r_c[2] <= 67'(r_prod);
                    6'd6: r_c[2] <= r_c[2] - 67'(r_prod);
                    default: ;
                endcase
            end
            L_ABS: begin
                for (int i = 0; i < 3; i++) begin
                    r_neg[i] <= r_c[i][66];
                    r_m[i]   <= r_c[i][66] ? 66'(-r_c[i]) : 66'(r_c[i]);
                end
            end
            L_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    if (w_or[65:31] != '0) r_m[i] <= r_m[i] >> 1;
                    else if (!w_or[30]) r_m[i] <= r_m[i] << 1;
                end
                r_x    <= '0;
                r_rem  <= '0;
                r_root <= '0;
            end
            L_LEN: begin
                if (r_k != 6'd0) r_len2 <= r_len2 + r_prod[63:0];
                r_x <= r_len2 + r_prod[63:0];
            end
            L_SQRT: begin
                r_x <= r_x << 2;
                if (w_rem2 >= w_t) begin
                    r_rem  <= w_rem2 - w_t;
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= w_rem2;
                    r_root <= {r_root[30:0], 1'b0};
                end
            end
            L_DIVI: begin
                r_drem <= {2'b0, w_dvd[61:31]};
                r_dvd  <= w_dvd[30:0];
            end
            L_DIV: begin
                r_dvd <= r_dvd << 1;
                if (w_drem2 >= {1'b0, r_root}) begin
                    r_drem <= w_drem2 - {1'b0, r_root};
                    r_q    <= {r_q[29:0], 1'b1};
                end else begin
                    r_drem <= w_drem2;
                    r_q    <= {r_q[29:0], 1'b0};
                end
                if (r_k == 6'd30) begin
                    r_n[r_ch] <= r_neg[r_ch] ?
                        -$signed({1'b0, r_q[29:0], (w_drem2 >= {1'b0, r_root})}) :
                         $signed({1'b0, r_q[29:0], (w_drem2 >= {1'b0, r_root})});
                    r_ch <= r_ch + 2'd1;
                end
            end
            L_OFF: begin
                if (r_k != 6'd0) r_acc <= r_acc + 67'(r_prod);
            end
            L_FIN: begin
                if (w_or == '0) begin
                    r_face <= '{degen: 1'b1, nx: '0, ny: '0, nz: '0, off: '0};
                end else begin
                    r_face.degen <= 1'b0;
                    r_face.nx    <= r_n[0];
                    r_face.ny    <= r_n[1];
                    r_face.nz    <= r_n[2];
                    if (w_sh > 37'sd2147483647) r_face.off <= 32'sh7fffffff;
                    else if (w_sh < -37'sd2147483648) r_face.off <= 32'sh80000000;
                    else r_face.off <= 32'(w_sh);
                end
            end
            default: ;
        endcase
    end

    assign o_ld.done = r_done;
    assign o_ld.face = r_face;

endmodule

// ----- sv/mpsd_checker.sv -----
// port checker for the nearest triangle plane block, bound to the top level
module mpsd_checker
    import mpsd_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input t_res o_res
);

    a_accept_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_done)
        else $error("transfer neither started work nor answered");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    a_busy_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("work ended without a result");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res.status == ST_EMPTY |->
            o_res.signed_distance == '0 && o_res.nearest_face == '0 && !o_res.is_inside)
        else $error("empty query result not zero");

    a_inside_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res.is_inside |-> o_res.signed_distance[31] && o_res.status == ST_OK)
        else $error("inside flag with non-negative distance");

endmodule

bind min_plane_signed_distance mpsd_checker u_mpsd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_res   (o_res)
);

// ----- tb/min_plane_signed_distance_tb.sv -----
// testbench for the nearest triangle plane block: random and directed commands, scoreboard check
`timescale 1ns / 100ps

module min_plane_signed_distance_tb;
    import mpsd_pkg::*;

    localparam int TABLE_DEPTH = 1024;

    class plane_tracker;
        logic signed [31:0] norm_x[TABLE_DEPTH];
        logic signed [31:0] norm_y[TABLE_DEPTH];
        logic signed [31:0] norm_z[TABLE_DEPTH];
        logic signed [31:0] plane_off[TABLE_DEPTH];
        bit                 flat[TABLE_DEPTH];
        int                 stored;
        t_res               pending_answers[$];
        int                 mismatches;
        int                 loads, flats, queries, misses, overflows;

        function new();
            stored = 0;
            mismatches = 0;
            loads = 0;
            flats = 0;
            queries = 0;
            misses = 0;
            overflows = 0;
        endfunction

        function automatic longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function automatic longint unsigned floor_root(longint unsigned v);
            longint unsigned acc, bitv;
            acc = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (v >= acc + bitv) begin
                    v = v - (acc + bitv);
                    acc = (acc >> 1) + bitv;
                end else begin
                    acc = acc >> 1;
                end
                bitv = bitv >> 2;
            end
            return acc;
        endfunction

        // builds the unit normal and offset of one triangle, returns the status
        function automatic logic [1:0] add_face(t_cmd c, int idx);
            longint             v0[3], e1[3], e2[3], nrm[3];
            logic signed [67:0] a1[3], a2[3], cr[3];
            logic [67:0]        mg[3], orv;
            longint unsigned    m31[3], len2, len, quo;
            longint             full;
            int                 p;
            v0[0] = longint'(c.first_x);
            v0[1] = longint'(c.first_y);
            v0[2] = longint'(c.first_z);
            e1[0] = longint'(c.second_x) - v0[0];
            e1[1] = longint'(c.second_y) - v0[1];
            e1[2] = longint'(c.second_z) - v0[2];
            e2[0] = longint'(c.third_x) - v0[0];
            e2[1] = longint'(c.third_y) - v0[1];
            e2[2] = longint'(c.third_z) - v0[2];
            for (int i = 0; i < 3; i++) begin
                a1[i] = 68'(e1[i]);
                a2[i] = 68'(e2[i]);
            end
            cr[0] = a1[1] * a2[2] - a1[2] * a2[1];
            cr[1] = a1[2] * a2[0] - a1[0] * a2[2];
            cr[2] = a1[0] * a2[1] - a1[1] * a2[0];
            orv = 0;
            for (int i = 0; i < 3; i++) begin
                mg[i] = cr[i] < 0 ? -cr[i] : cr[i];
                orv = orv | mg[i];
            end
            if (orv == 0) begin
                norm_x[idx] = 0;
                norm_y[idx] = 0;
                norm_z[idx] = 0;
                plane_off[idx] = 0;
                flat[idx] = 1;
                return ST_DEGEN;
            end
            p = 0;
            for (int b = 67; b >= 0; b--) begin
                if (orv[b]) begin
                    p = b;
                    break;
                end
            end
            len2 = 0;
            for (int i = 0; i < 3; i++) begin
                if (p > 30) m31[i] = 64'(mg[i] >> (p - 30)) & 64'h7FFF_FFFF;
                else m31[i] = 64'(mg[i] << (30 - p)) & 64'h7FFF_FFFF;
                len2 = len2 + m31[i] * m31[i];
            end
            len = floor_root(len2);
            for (int i = 0; i < 3; i++) begin
                quo = ((m31[i] << 30) + (len >> 1)) / len;
                nrm[i] = cr[i] < 0 ? -longint'(quo) : longint'(quo);
            end
            full = -(nrm[0] * v0[0] + nrm[1] * v0[1] + nrm[2] * v0[2]);
            norm_x[idx] = nrm[0][31:0];
            norm_y[idx] = nrm[1][31:0];
            norm_z[idx] = nrm[2][31:0];
            plane_off[idx] = 32'(sat32((full + (64'sd1 << 30)) >>> 31));
            flat[idx] = 0;
            return ST_OK;
        endfunction

        function automatic void accept_command(t_cmd c);
            t_res    r;
            longint  s, q30, v, best, best_val, a;
            bit      found;
            r = '0;
            case (c.opcode)
                OP_CLEAR: stored = 0;
                OP_LOAD: begin
                    if (stored >= TABLE_DEPTH) begin
                        r.status = ST_FULL;
                        overflows++;
                    end else begin
                        r.nearest_face = stored[9:0];
                        r.status = add_face(c, stored);
                        if (r.status == ST_DEGEN) flats++;
                        stored++;
                        loads++;
                    end
                end
                OP_QUERY: begin
                    found = 0;
                    best = 0;
                    best_val = 0;
                    queries++;
                    for (int i = 0; i < stored; i++) begin
                        if (flat[i]) continue;
                        s = longint'(norm_x[i]) * c.first_x + longint'(norm_y[i]) * c.first_y
                          + longint'(norm_z[i]) * c.first_z;
                        q30 = (s >>> 16) + longint'(plane_off[i]) * 32768;
                        v = (q30 + (64'sd1 << 13)) >>> 14;
                        a = v < 0 ? -v : v;
                        if (!found || a < best) begin
                            found = 1;
                            best = a;
                            best_val = v;
                            r.nearest_face = i[9:0];
                        end
                    end
                    if (found) begin
                        r.is_inside = best_val < 0;
                        r.signed_distance = 32'(sat32(best_val));
                    end else begin
                        r.status = ST_EMPTY;
                        misses++;
                    end
                end
                default: ;
            endcase
            pending_answers = {pending_answers, r};
        endfunction

        function automatic void compare_result(t_res got);
            t_res want;
            if (pending_answers.size() == 0) begin
                $error("result with nothing outstanding: %p", got);
                mismatches++;
                return;
            end
            want = pending_answers.pop_front();
            if (got.signed_distance !== want.signed_distance) begin
                $error("signed_distance expected %0d got %0d", want.signed_distance,
                       got.signed_distance);
                mismatches++;
            end
            if (got.nearest_face !== want.nearest_face) begin
                $error("nearest_face expected %0d got %0d", want.nearest_face,
                       got.nearest_face);
                mismatches++;
            end
            if (got.is_inside !== want.is_inside) begin
                $error("is_inside expected %0b got %0b", want.is_inside, got.is_inside);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status expected %0d got %0d", want.status, got.status);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_cmd i_cmd;
    logic busy;
    logic o_done;
    t_res o_res;

    plane_tracker tracker;

    min_plane_signed_distance dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_cmd  (i_cmd),
        .busy   (busy),
        .o_done (o_done),
        .o_res  (o_res)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) tracker.compare_result(o_res);
            if (start && !busy) tracker.accept_command(i_cmd);
        end
    end

    initial begin
        #36ms;
        $display("Mismatches found");
        $finish;
    end

    int burst_left;

    // one command transfer, with bursts and random gaps in between
    task automatic issue(t_cmd c);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10);
        end else begin
            burst_left--;
        end
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_answers.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
        endcase
    endfunction

    function automatic t_cmd tri_cmd(int mode);
        t_cmd c;
        c.opcode = OP_LOAD;
        c.first_x = coord(mode);
        c.first_y = coord(mode);
        c.first_z = coord(mode);
        c.second_x = coord(mode);
        c.second_y = coord(mode);
        c.second_z = coord(mode);
        c.third_x = coord(mode);
        c.third_y = coord(mode);
        c.third_z = coord(mode);
        case ($urandom_range(0, 9))
            0: {c.second_x, c.second_y, c.second_z} = {c.first_x, c.first_y, c.first_z};
            1: {c.third_x, c.third_y, c.third_z} = {c.second_x, c.second_y, c.second_z};
            default: ;
        endcase
        return c;
    endfunction

    function automatic t_cmd point_cmd(int mode);
        t_cmd c;
        c = tri_cmd(mode);
        c.opcode = OP_QUERY;
        return c;
    endfunction

    function automatic t_cmd plain_cmd(logic [1:0] op);
        t_cmd c;
        c = tri_cmd(0);
        c.opcode = op;
        return c;
    endfunction

    initial begin
        t_cmd c;
        int   r;
        tracker = new();
        burst_left = 0;
        start = 1'b0;
        i_cmd = '0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, flat faces, extremes, ties, no-op
        issue(point_cmd(1));
        issue(plain_cmd(OP_NOP));
        c = '0;
        c.opcode = OP_LOAD;
        issue(c);
        issue(point_cmd(1));
        c = '0;
        c.opcode = OP_LOAD;
        c.second_x = 32'sh0001_0000;
        c.third_y = 32'sh0001_0000;
        issue(c);
        issue(c);
        c.opcode = OP_QUERY;
        c.first_z = -32'sh0002_0000;
        issue(c);
        c.first_z = 32'sh7FFF_FFFF;
        issue(c);
        c = '0;
        c.opcode = OP_LOAD;
        c.first_x = 32'sh8000_0000;
        c.first_y = 32'sh8000_0000;
        c.first_z = 32'sh8000_0000;
        c.second_x = 32'sh7FFF_FFFF;
        c.second_y = 32'sh8000_0000;
        c.second_z = 32'sh7FFF_FFFF;
        c.third_x = 32'sh8000_0000;
        c.third_y = 32'sh7FFF_FFFF;
        c.third_z = 32'sh7FFF_FFFF;
        issue(c);
        c.second_x = 32'sh8000_0000;
        c.second_y = 32'sh7FFF_FFFF;
        c.third_x = 32'sh7FFF_FFFF;
        c.third_y = 32'sh8000_0000;
        issue(c);
        c = '0;
        c.opcode = OP_QUERY;
        c.first_x = 32'sh8000_0000;
        c.first_y = 32'sh7FFF_FFFF;
        c.first_z = 32'sh8000_0000;
        issue(c);
        c.first_x = 32'sh7FFF_FFFF;
        c.first_y = 32'sh8000_0000;
        c.first_z = 32'sh7FFF_FFFF;
        issue(c);
        issue(plain_cmd(OP_CLEAR));
        issue(point_cmd(0));
        drain();

        // random mix, table kept to at most 48 faces, with occasional clears
        for (int n = 0; n < 555; n++) begin
            r = $urandom_range(0, 99);
            if (r < 4) issue(plain_cmd(OP_CLEAR));
            else if (r < 7) issue(plain_cmd(OP_NOP));
            else if (r < 50 && tracker.stored < 48) issue(tri_cmd($urandom_range(0, 2)));
            else issue(point_cmd($urandom_range(0, 2)));
            if (n == 300) drain();
        end

        drain();
        repeat (40) @(posedge i_clk);
        $display("covered %0d loads (%0d flat), %0d queries (%0d with no usable face),",
                 tracker.loads, tracker.flats, tracker.queries, tracker.misses);
        $display("%0d loads into a full table, plus clears and no-ops", tracker.overflows);
        if (tracker.mismatches == 0 && tracker.pending_answers.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- min_plane_signed_distance.f -----
sv/mpsd_pkg.sv
sv/mpsd_load.sv
sv/min_plane_signed_distance.sv
sv/mpsd_checker.sv
tb/min_plane_signed_distance_tb.sv
